@@ rtl/isut_pkg.sv @@
// Package for the interval set union table: sizes, operation codes, item types
// and shared control types. Depends on nothing.
`default_nettype none
package isut_pkg;
    localparam int MaxIntervals = 16;
    localparam int IdxW = $clog2(MaxIntervals);
    localparam int CntW = $clog2(MaxIntervals + 1);
    localparam int BoundW = 32;

    typedef enum logic [1:0] {
        OP_UNITE = 2'd0,
        OP_QUERY = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NOP   = 2'd3
    } op_t;

    // One input item.
    typedef struct packed {
        op_t operation;
        logic signed [BoundW-1:0] first_bound;
        logic signed [BoundW-1:0] second_bound;
    } req_t;

    // One result item.
    typedef struct packed {
        logic is_member;
        logic [CntW-1:0] interval_count;
        logic table_full;
    } rsp_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;       // capture the accepted item
        logic rd_en;      // read entry at rd_idx
        logic [IdxW-1:0] rd_idx;
        logic wr_en;      // write wr_lo/wr_hi (selected by wr_sel) at wr_idx
        logic [IdxW-1:0] wr_idx;
        logic [1:0] wr_sel;
        logic clr;        // empty the table
        logic set_cnt;    // set count from cnt_val
        logic [CntW-1:0] cnt_val;
        logic merge_lo;   // widen working lo with read entry
        logic merge_hi;   // widen working hi with read entry
        logic res_load;   // latch the result
        logic res_member;
        logic res_full;
    } cmd_t;

    localparam logic [1:0] WSEL_WORK = 2'd0;  // write the working interval
    localparam logic [1:0] WSEL_READ = 2'd1;  // write the entry just read

    // Status from the datapath to the controller.
    typedef struct packed {
        op_t op;
        logic [CntW-1:0] count;
        logic up_lt_lo;   // read upper bound below working lo
        logic lo_le_hi;   // read lower bound not above working hi
        logic pt_lt_lo;   // query point below read lower bound
        logic pt_le_up;   // query point not above read upper bound
    } sts_t;
endpackage
`default_nettype wire

@@ rtl/isut_if.sv @@
// Valid/ready channel interface carrying one payload of type T.
// Depends on nothing.
`default_nettype none
interface isut_if #(parameter type T = logic) (input wire logic clk);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ rtl/isut_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`default_nettype none
module isut_ram #(
    parameter int Width = 32,
    parameter int Depth = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(Depth)-1:0] wr_addr,
    input  wire logic [Width-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(Depth)-1:0] rd_addr,
    output logic      [Width-1:0]         rd_data
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end
endmodule
`default_nettype wire

@@ rtl/isut_datapath.sv @@
// Datapath: bound memories, working interval, count and result register.
// Depends on isut_pkg and isut_ram.
`default_nettype none
module isut_datapath (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire isut_pkg::cmd_t                cmd,
    input  wire logic [1:0]                    in_op,
    input  wire logic signed [isut_pkg::BoundW-1:0] in_a,
    input  wire logic signed [isut_pkg::BoundW-1:0] in_b,
    output isut_pkg::sts_t                     sts,
    output logic                               res_member,
    output logic [4:0]                         res_count,
    output logic                               res_full
);
    import isut_pkg::*;

    logic signed [BoundW-1:0] lo_reg, hi_reg;
    logic [1:0]               op_reg;
    logic [CntW-1:0]          cnt_reg;
    logic signed [BoundW-1:0] rd_lo, rd_hi, wr_lo, wr_hi;

    isut_ram #(.Width(BoundW), .Depth(MaxIntervals)) u_lo (
        .clk(clk), .wr_en(cmd.wr_en), .wr_addr(cmd.wr_idx), .wr_data(wr_lo),
        .rd_en(cmd.rd_en), .rd_addr(cmd.rd_idx), .rd_data(rd_lo)
    );
    isut_ram #(.Width(BoundW), .Depth(MaxIntervals)) u_hi (
        .clk(clk), .wr_en(cmd.wr_en), .wr_addr(cmd.wr_idx), .wr_data(wr_hi),
        .rd_en(cmd.rd_en), .rd_addr(cmd.rd_idx), .rd_data(rd_hi)
    );

    always_comb
    begin
        if (cmd.wr_sel == WSEL_READ)
        begin
            wr_lo = rd_lo;
            wr_hi = rd_hi;
        end
        else
        begin
            wr_lo = lo_reg;
            wr_hi = hi_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg <= in_op;
            if (in_a > in_b)
            begin
                lo_reg <= in_b;
                hi_reg <= in_a;
            end
            else
            begin
                lo_reg <= in_a;
                hi_reg <= in_b;
            end
        end
        else
        begin
            if (cmd.merge_lo && rd_lo < lo_reg)
            begin
                lo_reg <= rd_lo;
            end
            if (cmd.merge_hi && rd_hi > hi_reg)
            begin
                hi_reg <= rd_hi;
            end
        end
    end

    // The query point is first_bound, so keep it apart from the swapped pair.
    logic signed [BoundW-1:0] pt_reg;
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            pt_reg <= in_a;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= '0;
            res_member <= 1'b0;
            res_count  <= '0;
            res_full   <= 1'b0;
        end
        else
        begin
            if (cmd.clr)
            begin
                cnt_reg <= '0;
            end
            else if (cmd.set_cnt)
            begin
                cnt_reg <= cmd.cnt_val;
            end
            if (cmd.res_load)
            begin
                res_member <= cmd.res_member;
                res_full   <= cmd.res_full;
                res_count  <= 5'(cnt_reg);
            end
        end
    end

    always_comb
    begin
        sts.op       = op_t'(op_reg);
        sts.count    = cnt_reg;
        sts.up_lt_lo = rd_hi < lo_reg;
        sts.lo_le_hi = rd_lo <= hi_reg;
        sts.pt_lt_lo = pt_reg < rd_lo;
        sts.pt_le_up = pt_reg <= rd_hi;
    end
endmodule
`default_nettype wire

@@ rtl/isut_ctrl.sv @@
// Controller: sequences the table walk, merge compaction and insertion shift.
// Depends on isut_pkg.
`default_nettype none
module isut_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  wire logic           out_ready,
    input  wire isut_pkg::sts_t sts,
    output isut_pkg::cmd_t      cmd
);
    import isut_pkg::*;

    typedef enum logic [11:0] {
        S_IDLE   = 12'b000000000001,
        S_DISP   = 12'b000000000010,
        S_QWAIT  = 12'b000000000100,
        S_FWAIT  = 12'b000000001000,
        S_JWAIT  = 12'b000000010000,
        S_MWRITE = 12'b000000100000,
        S_CWAIT  = 12'b000001000000,
        S_SWAIT  = 12'b000010000000,
        S_INS    = 12'b000100000000,
        S_PLACE  = 12'b001000000000,
        S_RES    = 12'b010000000000,
        S_OUT    = 12'b100000000000
    } state_t;

    state_t state_reg, state_next;
    // Walk index; CntW bits so it can reach the count itself.
    logic [CntW-1:0] i_reg, i_next, j_reg, j_next, k_reg, k_next;
    logic member_reg, member_next, full_reg, full_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            i_reg      <= '0;
            j_reg      <= '0;
            k_reg      <= '0;
            member_reg <= 1'b0;
            full_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            i_reg      <= i_next;
            j_reg      <= j_next;
            k_reg      <= k_next;
            member_reg <= member_next;
            full_reg   <= full_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);

    always_comb
    begin
        state_next  = state_reg;
        i_next      = i_reg;
        j_next      = j_reg;
        k_next      = k_reg;
        member_next = member_reg;
        full_next   = full_reg;
        cmd         = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load    = 1'b1;
                    member_next = 1'b0;
                    full_next   = 1'b0;
                    i_next      = '0;
                    state_next  = S_DISP;
                end
            end
            S_DISP:
            begin
                case (sts.op)
                    OP_UNITE, OP_QUERY:
                    begin
                        if (sts.count == '0)
                        begin
                            state_next = (sts.op == OP_UNITE) ? S_INS : S_RES;
                        end
                        else
                        begin
                            cmd.rd_en  = 1'b1;
                            cmd.rd_idx = IdxW'(0);
                            state_next = (sts.op == OP_UNITE) ? S_FWAIT : S_QWAIT;
                        end
                    end
                    OP_CLEAR:
                    begin
                        cmd.clr    = 1'b1;
                        state_next = S_RES;
                    end
                    default:
                    begin
                        state_next = S_RES;
                    end
                endcase
            end
            S_QWAIT:
            begin
                if (sts.pt_lt_lo)
                begin
                    state_next = S_RES;
                end
                else if (sts.pt_le_up)
                begin
                    member_next = 1'b1;
                    state_next  = S_RES;
                end
                else if (CntW'(i_reg + 1'b1) >= sts.count)
                begin
                    state_next = S_RES;
                end
                else
                begin
                    i_next     = CntW'(i_reg + 1'b1);
                    cmd.rd_en  = 1'b1;
                    cmd.rd_idx = IdxW'(i_reg + 1'b1);
                end
            end
            S_FWAIT:
            begin
                // Entry i has been read.
                if (sts.up_lt_lo)
                begin
                    if (CntW'(i_reg + 1'b1) >= sts.count)
                    begin
                        i_next     = CntW'(i_reg + 1'b1);
                        state_next = S_INS;
                    end
                    else
                    begin
                        i_next     = CntW'(i_reg + 1'b1);
                        cmd.rd_en  = 1'b1;
                        cmd.rd_idx = IdxW'(i_reg + 1'b1);
                    end
                end
                else if (sts.lo_le_hi)
                begin
                    cmd.merge_lo = 1'b1;
                    cmd.merge_hi = 1'b1;
                    j_next       = i_reg;
                    if (CntW'(i_reg + 1'b1) >= sts.count)
                    begin
                        state_next = S_MWRITE;
                    end
                    else
                    begin
                        cmd.rd_en  = 1'b1;
                        cmd.rd_idx = IdxW'(i_reg + 1'b1);
                        state_next = S_JWAIT;
                    end
                end
                else
                begin
                    state_next = S_INS;
                end
            end
            S_JWAIT:
            begin
                // Entry j+1 has been read.
                if (sts.lo_le_hi)
                begin
                    cmd.merge_hi = 1'b1;
                    j_next       = CntW'(j_reg + 1'b1);
                    if (CntW'(j_reg + 2'd2) >= sts.count)
                    begin
                        state_next = S_MWRITE;
                    end
                    else
                    begin
                        cmd.rd_en  = 1'b1;
                        cmd.rd_idx = IdxW'(j_reg + 2'd2);
                    end
                end
                else
                begin
                    state_next = S_MWRITE;
                end
            end
            S_MWRITE:
            begin
                cmd.wr_en   = 1'b1;
                cmd.wr_idx  = IdxW'(i_reg);
                cmd.wr_sel  = WSEL_WORK;
                k_next      = CntW'(j_reg + 1'b1);
                if (CntW'(j_reg + 1'b1) >= sts.count)
                begin
                    cmd.set_cnt = 1'b1;
                    cmd.cnt_val = CntW'(sts.count - (j_reg - i_reg));
                    state_next  = S_RES;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_idx = IdxW'(j_reg + 1'b1);
                    state_next = S_CWAIT;
                end
            end
            S_CWAIT:
            begin
                // Entry k has been read; move it down by j-i.
                cmd.wr_en  = 1'b1;
                cmd.wr_idx = IdxW'(k_reg - (j_reg - i_reg));
                cmd.wr_sel = WSEL_READ;
                if (CntW'(k_reg + 1'b1) >= sts.count)
                begin
                    cmd.set_cnt = 1'b1;
                    cmd.cnt_val = CntW'(sts.count - (j_reg - i_reg));
                    state_next  = S_RES;
                end
                else
                begin
                    k_next     = CntW'(k_reg + 1'b1);
                    cmd.rd_en  = 1'b1;
                    cmd.rd_idx = IdxW'(k_reg + 1'b1);
                end
            end
            S_INS:
            begin
                if (sts.count >= CntW'(MaxIntervals))
                begin
                    full_next  = 1'b1;
                    state_next = S_RES;
                end
                else if (sts.count == i_reg)
                begin
                    cmd.wr_en   = 1'b1;
                    cmd.wr_idx  = IdxW'(i_reg);
                    cmd.wr_sel  = WSEL_WORK;
                    cmd.set_cnt = 1'b1;
                    cmd.cnt_val = CntW'(sts.count + 1'b1);
                    state_next  = S_RES;
                end
                else
                begin
                    // Shift entries up from the top, entry k-1 into k.
                    k_next     = sts.count;
                    cmd.rd_en  = 1'b1;
                    cmd.rd_idx = IdxW'(sts.count - 1'b1);
                    state_next = S_SWAIT;
                end
            end
            S_SWAIT:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wr_idx = IdxW'(k_reg);
                cmd.wr_sel = WSEL_READ;
                if (CntW'(k_reg - 1'b1) == i_reg)
                begin
                    state_next = S_PLACE;
                end
                else
                begin
                    k_next     = CntW'(k_reg - 1'b1);
                    cmd.rd_en  = 1'b1;
                    cmd.rd_idx = IdxW'(k_reg - 2'd2);
                end
            end
            S_PLACE:
            begin
                cmd.wr_en   = 1'b1;
                cmd.wr_idx  = IdxW'(i_reg);
                cmd.wr_sel  = WSEL_WORK;
                cmd.set_cnt = 1'b1;
                cmd.cnt_val = CntW'(sts.count + 1'b1);
                state_next  = S_RES;
            end
            S_RES:
            begin
                cmd.res_load   = 1'b1;
                cmd.res_member = member_reg;
                cmd.res_full   = full_reg;
                state_next     = S_OUT;
            end
            S_OUT:
            begin
                if (out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end
endmodule
`default_nettype wire

@@ rtl/interval_set_union_table.sv @@
// Top level of the interval set union table.
// Depends on isut_pkg, isut_if, isut_ctrl and isut_datapath.
//
// Usage: items enter on in_ch (operation, first_bound, second_bound) and one
// result leaves on out_ch (is_member, interval_count, table_full) per item.
// The block works on one item at a time and walks the bound memories at one
// entry per cycle through their registered read port, which sets the timing.
// A clear or unused code touches no entry, a query walks the stored entries
// until it can decide, and a unite either merges with compaction, inserts
// with the upward shift, or is dropped when the table is full.
// After reset the table is empty; memory contents are not cleared and are
// never read before being written. The result is held in an output register
// while the receiver stalls, and no new item is taken until it is taken.
`default_nettype none
module interval_set_union_table (
    input wire logic clk,
    input wire logic rst_n,
    isut_if.sink     in_ch,
    isut_if.source   out_ch
);
    import isut_pkg::*;

    cmd_t cmd;
    sts_t sts;
    logic in_ready, out_valid;

    isut_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_ch.valid), .in_ready(in_ready),
        .out_valid(out_valid), .out_ready(out_ch.ready),
        .sts(sts), .cmd(cmd)
    );

    isut_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd),
        .in_op(in_ch.data.operation),
        .in_a(in_ch.data.first_bound), .in_b(in_ch.data.second_bound),
        .sts(sts),
        .res_member(out_ch.data.is_member),
        .res_count(out_ch.data.interval_count),
        .res_full(out_ch.data.table_full)
    );

    assign in_ch.ready  = in_ready;
    assign out_ch.valid = out_valid;

`ifndef NO_ASSERTIONS
    a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ch.ready && out_ch.valid)) else $error("ready while result pending");
    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        sts.count <= CntW'(MaxIntervals)) else $error("count overflow");
    a_full_unite: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.data.table_full |-> !out_ch.data.is_member)
        else $error("full and member together");
`endif
endmodule
`default_nettype wire
